/* sv/mts_pkg.sv */
// Shared types, codes and tables of the mash tun process sequencer.
package mts_pkg;

  localparam int TEMP_W       = 10;
  localparam int TIME_W       = 16;
  localparam int TEMP_BITS_DF = 10;
  localparam logic [7:0] STEP_RESET  = 8'd100;
  localparam logic [7:0] SPI_STATUS  = 8'hFF;
  localparam logic [3:0] MOTOR_HOME  = 4'd0;
  localparam logic [3:0] MOTOR_FIRST = 4'd1;
  localparam logic [3:0] MOTOR_LAST  = 4'd8;

  typedef enum logic [1:0] {
    REQ_CTRL  = 2'd0,
    REQ_MOTOR = 2'd1,
    REQ_SPI   = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    LV_EMPTY     = 2'd0,
    LV_NOT_EMPTY = 2'd1,
    LV_FULL      = 2'd2
  } level_t;

  typedef enum logic [2:0] {
    PH_WAIT     = 3'd0,
    PH_FILL     = 3'd1,
    PH_BELOW    = 3'd2,
    PH_AT       = 3'd3,
    PH_FINISHED = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]               req_type;
    logic                     low_sensor_wet;
    logic                     high_sensor_wet;
    logic [TEMP_W-1:0]        temp_sample;
    logic [7:0]               spi_flag;
    logic signed [TIME_W-1:0] spi_time;
    logic [TEMP_W-1:0]        spi_temp;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               level_code;
    logic                     stirrer_on;
    logic                     heater_on;
    logic [3:0]               coil_pattern;
    logic [2:0]               phase_code;
    logic signed [TIME_W-1:0] time_left;
    logic [TEMP_W-1:0]        temp_now;
    logic                     reply_valid;
  } out_item_t;

  // Control state that moves between the step logic and the top level.
  typedef struct packed {
    level_t                   level;
    logic                     stir;
    logic                     heater;
    phase_t                   phase;
    logic [3:0]               motor_phase;
    logic [3:0]               coil;
    logic signed [TIME_W-1:0] time_left;
  } ctl_state_t;

  // Half-step coil drive: init, A, AB, B, BC, C, CD, D, DA.
  function automatic logic [3:0] coil_of(input logic [3:0] ph);
    logic [3:0] c;
    unique case (ph)
      4'd0:    c = 4'd0;
      4'd1:    c = 4'd1;
      4'd2:    c = 4'd3;
      4'd3:    c = 4'd2;
      4'd4:    c = 4'd6;
      4'd5:    c = 4'd4;
      4'd6:    c = 4'd12;
      4'd7:    c = 4'd8;
      4'd8:    c = 4'd9;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

/* sv/mts_step.sv */
// Next-state logic of the sequencer for one item.
module mts_step #(
  parameter int TW = mts_pkg::TEMP_W
) (
  input  mts_pkg::in_item_t   item,
  input  mts_pkg::ctl_state_t st,
  input  logic [TW-1:0]       cap_temp,
  input  logic [TW-1:0]       set_temp,
  input  logic [7:0]          step_dec,
  output mts_pkg::ctl_state_t st_next,
  output logic [TW-1:0]       cap_temp_next,
  output logic [TW-1:0]       set_temp_next,
  output logic                reply
);

  logic signed [mts_pkg::TIME_W:0]   diff;
  logic signed [mts_pkg::TIME_W-1:0] dec_time;
  logic                              dec_done;
  logic                              time_pos;
  mts_pkg::level_t                   lvl;
  logic                              stir;

  // Countdown with saturation at the most negative value.
  always_comb begin
    diff = $signed({st.time_left[mts_pkg::TIME_W-1], st.time_left})
         - $signed({9'd0, step_dec});
    if (diff[mts_pkg::TIME_W] && !diff[mts_pkg::TIME_W-1]) begin
      dec_time = {1'b1, {(mts_pkg::TIME_W-1){1'b0}}};
    end else begin
      dec_time = diff[mts_pkg::TIME_W-1:0];
    end
    dec_done = dec_time[mts_pkg::TIME_W-1] || (dec_time == '0);
    time_pos = !st.time_left[mts_pkg::TIME_W-1] && (st.time_left != '0);
  end

  always_comb begin
    if (!item.low_sensor_wet) begin
      lvl = mts_pkg::LV_EMPTY;
    end else if (item.high_sensor_wet) begin
      lvl = mts_pkg::LV_FULL;
    end else begin
      lvl = mts_pkg::LV_NOT_EMPTY;
    end
    priority if (!st.stir && lvl == mts_pkg::LV_NOT_EMPTY) begin
      stir = 1'b1;
    end else if (st.stir && lvl == mts_pkg::LV_EMPTY) begin
      stir = 1'b0;
    end else begin
      stir = st.stir;
    end
  end

  always_comb begin
    st_next       = st;
    cap_temp_next = cap_temp;
    set_temp_next = set_temp;
    reply         = 1'b0;
    unique case (item.req_type)
      mts_pkg::REQ_CTRL: begin
        st_next.level = lvl;
        st_next.stir  = stir;
        unique case (st.phase)
          mts_pkg::PH_WAIT: begin
            cap_temp_next = item.temp_sample[TW-1:0];
            if (set_temp != '0 && time_pos) st_next.phase = mts_pkg::PH_FILL;
          end
          mts_pkg::PH_FILL: begin
            cap_temp_next = item.temp_sample[TW-1:0];
            if (lvl == mts_pkg::LV_FULL) st_next.phase = mts_pkg::PH_AT;
          end
          mts_pkg::PH_AT: begin
            cap_temp_next     = item.temp_sample[TW-1:0];
            st_next.time_left = dec_time;
            priority if (dec_done) begin
              st_next.phase = mts_pkg::PH_FINISHED;
            end else if (item.temp_sample[TW-1:0] < set_temp) begin
              st_next.phase = mts_pkg::PH_BELOW;
            end else begin
              st_next.phase = mts_pkg::PH_AT;
            end
          end
          mts_pkg::PH_BELOW: begin
            cap_temp_next     = item.temp_sample[TW-1:0];
            st_next.time_left = dec_time;
            priority if (dec_done) begin
              st_next.phase = mts_pkg::PH_FINISHED;
            end else if (item.temp_sample[TW-1:0] >= set_temp) begin
              st_next.phase = mts_pkg::PH_AT;
            end else begin
              st_next.phase = mts_pkg::PH_BELOW;
            end
          end
          mts_pkg::PH_FINISHED: begin
            set_temp_next = '0;
            st_next.phase = mts_pkg::PH_WAIT;
          end
          default: ;
        endcase
        // heater follows the new phase; wait keeps it
        priority if (st_next.phase == mts_pkg::PH_BELOW) begin
          st_next.heater = 1'b1;
        end else if (st_next.phase == mts_pkg::PH_FILL || st_next.phase == mts_pkg::PH_AT
                     || st_next.phase == mts_pkg::PH_FINISHED) begin
          st_next.heater = 1'b0;
        end else begin
          st_next.heater = st.heater;
        end
      end
      mts_pkg::REQ_MOTOR: begin
        priority if (st.motor_phase > mts_pkg::MOTOR_LAST) begin
          st_next.coil        = 4'd0;
          st_next.motor_phase = mts_pkg::MOTOR_HOME;
        end else if (st.motor_phase == mts_pkg::MOTOR_HOME) begin
          st_next.coil        = mts_pkg::coil_of(st.motor_phase);
          st_next.motor_phase = mts_pkg::MOTOR_FIRST;
        end else if (st.stir) begin
          st_next.coil        = mts_pkg::coil_of(st.motor_phase);
          st_next.motor_phase = (st.motor_phase == mts_pkg::MOTOR_LAST)
                              ? mts_pkg::MOTOR_FIRST : st.motor_phase + 4'd1;
        end else begin
          st_next.coil = mts_pkg::coil_of(st.motor_phase);
        end
      end
      mts_pkg::REQ_SPI: begin
        if (item.spi_flag == mts_pkg::SPI_STATUS) begin
          reply = 1'b1;
        end else begin
          st_next.time_left = item.spi_time;
          set_temp_next     = item.spi_temp[TW-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

/* sv/mash_tun_process_sequencer.sv */
// Mash tun process sequencer: one item in, one result out, one item per clock cycle
// sustained while results are taken. Each item passes an input register and a result
// register, entering the result register once it is free; state updates are done by
// combinational next-state logic between the two. A result that is not taken holds
// the result register, and one more item can wait in the input register.
module mash_tun_process_sequencer #(
  parameter int TEMP_BITS = mts_pkg::TEMP_BITS_DF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_we,
  input  logic [7:0]         step_decrement,
  input  logic               in_valid,
  output logic               in_ready,
  input  mts_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output mts_pkg::out_item_t out_item
);

  localparam int TW = (TEMP_BITS < mts_pkg::TEMP_W) ? TEMP_BITS : mts_pkg::TEMP_W;

  logic [7:0]          step_reg;
  logic                stage_valid;
  mts_pkg::in_item_t   stage_item;
  logic                move;
  mts_pkg::ctl_state_t st;
  mts_pkg::ctl_state_t st_next;
  logic [TW-1:0]       cap_temp;
  logic [TW-1:0]       cap_temp_next;
  logic [TW-1:0]       set_temp;
  logic [TW-1:0]       set_temp_next;
  logic                reply;

  assign move     = stage_valid && (!out_valid || out_ready);
  assign in_ready = !stage_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= mts_pkg::STEP_RESET;
    end else if (step_we) begin
      step_reg <= step_decrement;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) stage_item <= in_item;
  end

  mts_step #(.TW(TW)) u_step (
    .item          (stage_item),
    .st            (st),
    .cap_temp      (cap_temp),
    .set_temp      (set_temp),
    .step_dec      (step_reg),
    .st_next       (st_next),
    .cap_temp_next (cap_temp_next),
    .set_temp_next (set_temp_next),
    .reply         (reply)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{level: mts_pkg::LV_EMPTY, stir: 1'b0, heater: 1'b0,
              phase: mts_pkg::PH_WAIT, motor_phase: mts_pkg::MOTOR_HOME,
              coil: 4'd0, time_left: '0};
      cap_temp  <= '0;
      set_temp  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        st       <= st_next;
        cap_temp <= cap_temp_next;
        set_temp <= set_temp_next;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_item.level_code   <= st_next.level;
      out_item.stirrer_on   <= st_next.stir;
      out_item.heater_on    <= st_next.heater;
      out_item.coil_pattern <= st_next.coil;
      out_item.phase_code   <= st_next.phase;
      out_item.time_left    <= st_next.time_left;
      out_item.temp_now     <= mts_pkg::TEMP_W'(cap_temp_next);
      out_item.reply_valid  <= reply;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> stage_valid && out_valid && !out_ready)
    else $error("input stalled without a held result");

  a_heater_below: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.phase_code == mts_pkg::PH_BELOW |-> out_item.heater_on)
    else $error("heater off while below temperature");

  a_heater_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.phase_code == mts_pkg::PH_FILL
                  || out_item.phase_code == mts_pkg::PH_AT
                  || out_item.phase_code == mts_pkg::PH_FINISHED)
    |-> !out_item.heater_on)
    else $error("heater on outside below temperature");

  a_stir_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.level_code == mts_pkg::LV_EMPTY |-> !out_item.stirrer_on)
    else $error("stirrer on with empty vessel");

endmodule
